// ===== hdl/pth_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pth_pkg
// Shared types, codes and constants of the pocket tree heap unit.
// ----------------------------------------------------------------------------
package pth_pkg;

    localparam int OP_W       = 3;
    localparam int NODE_IDX_W = 4;
    localparam int PORT_FIT_W = 32;
    localparam int PORT_TAG_W = 16;
    localparam int SWAP_W     = 3;

    localparam logic [SWAP_W-1:0] SWAP_MAX = 3'd7;

    localparam logic [OP_W-1:0] OP_WRITE_CURRENT = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_POCKET  = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE        = 3'd2;
    localparam logic [OP_W-1:0] OP_SIFT_DOWN     = 3'd3;
    localparam logic [OP_W-1:0] OP_SIFT_UP       = 3'd4;
    localparam logic [OP_W-1:0] OP_READ          = 3'd5;

    localparam int S_TUSER_W   = OP_W;
    localparam int IN_NODE_LSB = 0;
    localparam int IN_FIT_LSB  = IN_NODE_LSB + NODE_IDX_W;
    localparam int IN_TAG_LSB  = IN_FIT_LSB + PORT_FIT_W;
    localparam int IN_BITS     = IN_TAG_LSB + PORT_TAG_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS  = 2 * (PORT_FIT_W + PORT_TAG_W) + SWAP_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_WRITE,
        CMD_RD_NODE,
        CMD_UPDATE,
        CMD_TAKE,
        CMD_CHILD,
        CMD_CHILD_END,
        CMD_DOWN_DEC,
        CMD_DOWN_SW,
        CMD_UP_RD,
        CMD_UP_CMP,
        CMD_UP_WR,
        CMD_RD_ORIG,
        CMD_OUT
    } pth_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_range;
        logic            is_leaf;
        logic            is_root;
        logic            child_last;
        logic            clear_last;
        logic            down_swap;
        logic            up_swap;
        logic            out_busy;
    } pth_stat_t;

    function automatic int pth_node_count(input int depth, input int branch);
        int total;
        int level;
        total = 0;
        level = 1;
        for (int i = 0; i < depth; i++) begin
            total = total + level;
            level = level * branch;
        end
        return total;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pocket_tree_heap_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pocket_tree_heap_unit
// Complete d-ary tree of pocket/current slot pairs with pocket update,
// sift down, sift up, slot writes and node reads.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                     tuser
// s_       in   node_index, new_fitness, new_tag           operation
// m_       out  pocket fit/tag, current fit/tag, swaps     -
//
// After reset a clearing pass writes every node, one per cycle (13 nodes by
// default); no transaction is accepted until it ends. A read, a slot write or
// a pocket update passes dispatch and a final node read before its result; an
// out-of-range node skips the final read. s_tready rises with the result.
// Sift up reads, compares and writes per level climbed, and reads and compares
// once more when it stops below the root; sift down runs child reads, child
// end, decide, swap, node read and update per level descended, and child reads,
// child end and decide when it stops above a leaf. The single read port of the
// node memories sets this order. One transaction is in work at a time; a
// result not yet taken stalls only the completion of the following transaction.
// ----------------------------------------------------------------------------
module pocket_tree_heap_unit
    import pth_pkg::*;
#(
    parameter int TREE_DEPTH   = 3,
    parameter int BRANCHING    = 3,
    parameter int FITNESS_BITS = 32,
    parameter int TAG_BITS     = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // node_index[3:0], new_fitness[35:4], new_tag[51:36], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // operation[2:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pocket_fitness[31:0], pocket_tag[47:32], current_fitness[79:48],
    // current_tag[95:80], swap_count[98:96], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    pth_cmd_t  cmd;
    pth_stat_t stat;

    pth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pth_datapath #(
        .TREE_DEPTH   (TREE_DEPTH),
        .BRANCHING    (BRANCHING),
        .FITNESS_BITS (FITNESS_BITS),
        .TAG_BITS     (TAG_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/pth_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pth_ctrl
// Sequencer of the pocket tree heap: steps each operation through the
// datapath by issuing one command per cycle.
// ----------------------------------------------------------------------------
module pth_ctrl
    import pth_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire pth_stat_t stat,
    output pth_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_DN_CH,
        S_DN_END,
        S_DN_DEC,
        S_DN_SW,
        S_DN_RD,
        S_DN_UPD,
        S_UP_RD,
        S_UP_CMP,
        S_UP_WR,
        S_FINAL,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_CLEAR: begin
                cmd = CMD_CLEAR;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.out_range) begin
                    state_next = S_OUT;
                end else begin
                    case (stat.op)
                        OP_WRITE_CURRENT, OP_WRITE_POCKET: begin
                            cmd        = CMD_WRITE;
                            state_next = S_FINAL;
                        end
                        OP_UPDATE: begin
                            cmd        = CMD_UPDATE;
                            state_next = S_FINAL;
                        end
                        OP_SIFT_DOWN: begin
                            cmd        = CMD_UPDATE;
                            state_next = stat.is_leaf ? S_FINAL : S_DN_CH;
                        end
                        OP_SIFT_UP: begin
                            cmd        = CMD_TAKE;
                            state_next = stat.is_root ? S_FINAL : S_UP_RD;
                        end
                        default: begin
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end
            S_DN_CH: begin
                cmd = CMD_CHILD;
                if (stat.child_last) begin
                    state_next = S_DN_END;
                end
            end
            S_DN_END: begin
                cmd        = CMD_CHILD_END;
                state_next = S_DN_DEC;
            end
            S_DN_DEC: begin
                cmd        = CMD_DOWN_DEC;
                state_next = stat.down_swap ? S_DN_SW : S_FINAL;
            end
            S_DN_SW: begin
                cmd        = CMD_DOWN_SW;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                cmd        = CMD_RD_NODE;
                state_next = S_DN_UPD;
            end
            S_DN_UPD: begin
                cmd        = CMD_UPDATE;
                state_next = stat.is_leaf ? S_FINAL : S_DN_CH;
            end
            S_UP_RD: begin
                cmd        = CMD_UP_RD;
                state_next = S_UP_CMP;
            end
            S_UP_CMP: begin
                cmd        = CMD_UP_CMP;
                state_next = stat.up_swap ? S_UP_WR : S_FINAL;
            end
            S_UP_WR: begin
                cmd        = CMD_UP_WR;
                state_next = stat.is_root ? S_FINAL : S_UP_RD;
            end
            S_FINAL: begin
                cmd        = CMD_RD_ORIG;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_busy) begin
                    cmd = CMD_RD_ORIG;
                end else begin
                    cmd        = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/pth_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pth_datapath
// Node memories, walk registers, comparators and result register of the
// pocket tree heap.
// ----------------------------------------------------------------------------
module pth_datapath
    import pth_pkg::*;
#(
    parameter int TREE_DEPTH   = 3,
    parameter int BRANCHING    = 3,
    parameter int FITNESS_BITS = 32,
    parameter int TAG_BITS     = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pth_cmd_t             cmd,
    output pth_stat_t                 stat,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int NODE_COUNT = pth_node_count(TREE_DEPTH, BRANCHING);
    localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int KW         = $clog2(BRANCHING);
    localparam int FW         = NODE_W + KW + 1;
    localparam int SLOT_W     = FITNESS_BITS + TAG_BITS;
    localparam int PAR_SHIFT  = NODE_W + KW;
    localparam int PROD_W     = NODE_W + PAR_SHIFT;
    localparam logic [PAR_SHIFT-1:0] PAR_MULT =
        PAR_SHIFT'(((64'd1 << PAR_SHIFT) + 64'(BRANCHING) - 64'd1) / 64'(BRANCHING));

    logic [SLOT_W-1:0] pmem [NODE_COUNT];
    logic [SLOT_W-1:0] cmem [NODE_COUNT];

    logic [NODE_IDX_W-1:0] in_node;
    logic [PORT_FIT_W-1:0] in_fit;
    logic [PORT_TAG_W-1:0] in_tag;

    logic [OP_W-1:0]         op_reg;
    logic [NODE_W-1:0]       orig_reg;
    logic [NODE_W-1:0]       n_reg;
    logic [NODE_W-1:0]       par_reg;
    logic [NODE_W-1:0]       best_idx_reg;
    logic [NODE_W-1:0]       pr_addr_reg;
    logic [NODE_W-1:0]       clr_reg;
    logic [KW-1:0]           k_reg;
    logic [FITNESS_BITS-1:0] fit_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    logic [SLOT_W-1:0]       pocket_reg;
    logic [SLOT_W-1:0]       best_reg;
    logic [SLOT_W-1:0]       prd_reg;
    logic [SLOT_W-1:0]       crd_reg;
    logic [SWAP_W-1:0]       swaps_reg;
    logic                    oor_reg;
    logic                    m_tvalid_reg;
    logic [PORT_FIT_W-1:0]   out_pfit_reg;
    logic [PORT_TAG_W-1:0]   out_ptag_reg;
    logic [PORT_FIT_W-1:0]   out_cfit_reg;
    logic [PORT_TAG_W-1:0]   out_ctag_reg;
    logic [SWAP_W-1:0]       out_swaps_reg;

    logic [NODE_W-1:0]       pr_addr;
    logic                    pw_en;
    logic [NODE_W-1:0]       pw_addr;
    logic [SLOT_W-1:0]       pw_data;
    logic                    cw_en;
    logic [NODE_W-1:0]       cw_addr;
    logic [SLOT_W-1:0]       cw_data;

    logic [FITNESS_BITS-1:0] prd_fit;
    logic [FITNESS_BITS-1:0] crd_fit;
    logic [FITNESS_BITS-1:0] pocket_fit;
    logic [FITNESS_BITS-1:0] lead_fit;
    logic [FW-1:0]           first_child;
    logic [NODE_W-1:0]       child_addr;
    logic [PROD_W-1:0]       par_prod;
    logic                    upd_swap;
    logic                    down_swap;
    logic                    up_swap;
    logic                    child_take;
    logic                    end_take;
    logic [SWAP_W-1:0]       swaps_inc;

    assign in_node = s_tdata[IN_NODE_LSB +: NODE_IDX_W];
    assign in_fit  = s_tdata[IN_FIT_LSB +: PORT_FIT_W];
    assign in_tag  = s_tdata[IN_TAG_LSB +: PORT_TAG_W];

    assign prd_fit    = prd_reg[SLOT_W-1:TAG_BITS];
    assign crd_fit    = crd_reg[SLOT_W-1:TAG_BITS];
    assign pocket_fit = pocket_reg[SLOT_W-1:TAG_BITS];
    assign lead_fit   = best_reg[SLOT_W-1:TAG_BITS];

    assign first_child = FW'(n_reg) * FW'(BRANCHING) + FW'(1);
    assign child_addr  = NODE_W'(first_child + FW'(k_reg));
    assign par_prod    = PROD_W'(NODE_W'(n_reg - NODE_W'(1))) * PROD_W'(PAR_MULT);

    assign upd_swap   = prd_fit > crd_fit;
    assign down_swap  = pocket_fit > lead_fit;
    assign up_swap    = pocket_fit < prd_fit;
    assign end_take   = prd_fit < lead_fit;
    assign child_take = (k_reg == KW'(1)) || end_take;
    assign swaps_inc  = (swaps_reg == SWAP_MAX) ? swaps_reg : swaps_reg + SWAP_W'(1);

    always_comb begin
        pr_addr = orig_reg;
        pw_en   = 1'b0;
        pw_addr = n_reg;
        pw_data = pocket_reg;
        cw_en   = 1'b0;
        cw_addr = n_reg;
        cw_data = prd_reg;
        case (cmd)
            CMD_CLEAR: begin
                pw_en   = 1'b1;
                pw_addr = clr_reg;
                pw_data = '0;
                cw_en   = 1'b1;
                cw_addr = clr_reg;
                cw_data = '0;
            end
            CMD_LOAD: begin
                pr_addr = NODE_W'(in_node);
            end
            CMD_WRITE: begin
                pw_data = {fit_reg, tag_reg};
                cw_data = {fit_reg, tag_reg};
                pw_en   = (op_reg == OP_WRITE_POCKET);
                cw_en   = (op_reg == OP_WRITE_CURRENT);
            end
            CMD_RD_NODE: begin
                pr_addr = n_reg;
            end
            CMD_UPDATE: begin
                pr_addr = n_reg;
                pw_en   = upd_swap;
                pw_data = crd_reg;
                cw_en   = upd_swap;
                cw_data = prd_reg;
            end
            CMD_CHILD: begin
                pr_addr = child_addr;
            end
            CMD_DOWN_DEC: begin
                pw_en   = down_swap;
                pw_data = best_reg;
            end
            CMD_DOWN_SW: begin
                pw_en   = 1'b1;
                pw_addr = best_idx_reg;
                pw_data = pocket_reg;
            end
            CMD_UP_RD: begin
                pr_addr = par_reg;
            end
            CMD_UP_CMP: begin
                pw_en   = up_swap;
                pw_data = prd_reg;
            end
            CMD_UP_WR: begin
                pw_en   = 1'b1;
                pw_data = pocket_reg;
            end
            default: begin
                pr_addr = orig_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pw_en) begin
            pmem[pw_addr] <= pw_data;
        end
        if (cw_en) begin
            cmem[cw_addr] <= cw_data;
        end
        prd_reg <= pmem[pr_addr];
        crd_reg <= cmem[pr_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            swaps_reg    <= '0;
            oor_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd == CMD_CLEAR) begin
                clr_reg <= clr_reg + NODE_W'(1);
            end
            if (cmd == CMD_LOAD) begin
                swaps_reg <= '0;
                oor_reg   <= (32'(in_node) >= 32'(NODE_COUNT));
            end else if ((cmd == CMD_UPDATE && upd_swap) ||
                         (cmd == CMD_DOWN_DEC && down_swap) ||
                         (cmd == CMD_UP_CMP && up_swap)) begin
                swaps_reg <= swaps_inc;
            end
            if (cmd == CMD_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pr_addr_reg <= pr_addr;
        par_reg     <= NODE_W'(par_prod >> PAR_SHIFT);
        case (cmd)
            CMD_LOAD: begin
                op_reg   <= s_tuser;
                orig_reg <= NODE_W'(in_node);
                n_reg    <= NODE_W'(in_node);
                fit_reg  <= FITNESS_BITS'(in_fit);
                tag_reg  <= TAG_BITS'(in_tag);
            end
            CMD_UPDATE: begin
                pocket_reg <= upd_swap ? crd_reg : prd_reg;
                k_reg      <= '0;
            end
            CMD_TAKE: begin
                pocket_reg <= prd_reg;
            end
            CMD_CHILD: begin
                k_reg <= k_reg + KW'(1);
                if (k_reg != '0 && child_take) begin
                    best_reg     <= prd_reg;
                    best_idx_reg <= pr_addr_reg;
                end
            end
            CMD_CHILD_END: begin
                if (end_take) begin
                    best_reg     <= prd_reg;
                    best_idx_reg <= pr_addr_reg;
                end
            end
            CMD_DOWN_SW: begin
                n_reg <= best_idx_reg;
            end
            CMD_UP_CMP: begin
                if (up_swap) begin
                    n_reg <= par_reg;
                end
            end
            CMD_OUT: begin
                if (oor_reg) begin
                    out_pfit_reg  <= '0;
                    out_ptag_reg  <= '0;
                    out_cfit_reg  <= '0;
                    out_ctag_reg  <= '0;
                    out_swaps_reg <= '0;
                end else begin
                    out_pfit_reg  <= PORT_FIT_W'(prd_fit);
                    out_ptag_reg  <= PORT_TAG_W'(prd_reg[TAG_BITS-1:0]);
                    out_cfit_reg  <= PORT_FIT_W'(crd_fit);
                    out_ctag_reg  <= PORT_TAG_W'(crd_reg[TAG_BITS-1:0]);
                    out_swaps_reg <= swaps_reg;
                end
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign stat.op         = op_reg;
    assign stat.out_range  = oor_reg;
    assign stat.is_leaf    = (first_child >= FW'(NODE_COUNT));
    assign stat.is_root    = (n_reg == '0);
    assign stat.child_last = (k_reg == KW'(BRANCHING - 1));
    assign stat.clear_last = (clr_reg == NODE_W'(NODE_COUNT - 1));
    assign stat.down_swap  = down_swap;
    assign stat.up_swap    = up_swap;
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_BITS){1'b0}}, out_swaps_reg, out_ctag_reg,
                       out_cfit_reg, out_ptag_reg, out_pfit_reg};

    a_oor_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (oor_reg && cmd != CMD_CLEAR && cmd != CMD_LOAD) |-> (!pw_en && !cw_en))
        else $error("memory written for an out-of-range node");

    a_parent_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_UP_RD) |-> (par_reg < n_reg))
        else $error("parent index not below node index");

    a_child_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_CHILD) |-> ((NODE_W + 1)'(pr_addr) < (NODE_W + 1)'(NODE_COUNT)))
        else $error("child address beyond the tree");

    a_down_deeper: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_DOWN_SW) |-> (best_idx_reg > n_reg))
        else $error("sift down does not move to a child");

endmodule
`default_nettype wire
